>>> src/q2e_pkg.sv
// Shared types, constants and the arctangent table of the quaternion to Euler angle block.
// Used by every module in src; depends on nothing else.
package q2e_pkg;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int Q_W            = 16;
  localparam int IN_W           = 4 * Q_W;
  localparam int OUT_W          = 3 * Q_W;
  localparam int PROD_W         = 2 * Q_W;
  localparam int SUM_W          = 36;
  localparam int ANG_W          = 32;
  localparam int NORM_MSB       = 29;
  localparam int NORM_STAGES    = 5;
  localparam int GRP_W          = 6;
  localparam int GRP_N          = SUM_W / GRP_W;
  localparam int P_W            = $clog2(SUM_W);
  localparam int LEAD_W         = $clog2(GRP_W);
  localparam int S30_W          = 32;
  localparam int S30_SHL        = 30 - 2 * QUAT_FRAC_BITS;
  localparam int MAG_W          = 30;
  localparam int SQ_W           = 2 * MAG_W;
  localparam int ISQ_W          = SQ_W + 2;
  localparam int ISQ_STEPS      = MAG_W + 1;
  localparam int ROOT_W         = MAG_W + 1;
  localparam int ATAN_LEN       = 24;

  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(64'd1 << (2 * QUAT_FRAC_BITS));
  localparam logic [ISQ_W-1:0]        SQ_ONE = ISQ_W'(64'd1 << SQ_W);
  localparam logic [ANG_W-1:0]        HALF_TURN = 32'h8000_0000;
  localparam logic [ANG_W-1:0]        ROUND_HALF = 32'h0000_8000;
  localparam logic signed [Q_W-1:0]   QUARTER_POS = 16'sd16384;
  localparam logic signed [Q_W-1:0]   QUARTER_NEG = -16'sd16384;

  localparam logic [ANG_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic [ANG_W-1:0]        ang;
    logic                    zero;
  } rot_t;

  typedef struct packed {
    logic [ISQ_W-1:0] rem;
    logic [ISQ_W-1:0] root;
  } isq_t;

  typedef struct packed {
    logic sat;
    logic spos;
  } pflag_t;

endpackage

>>> src/q2e_sqrt_cell.sv
// One cell of the pipelined integer square root: settles one result bit per cycle while en is high.
// Depends on q2e_pkg.
module q2e_sqrt_cell #(
  parameter int BITPOS = 0
) (
  input  logic            clk,
  input  logic            en,
  input  q2e_pkg::isq_t   d,
  output q2e_pkg::isq_t   q
);

  localparam logic [q2e_pkg::ISQ_W-1:0] BIT = q2e_pkg::ISQ_W'(1) << BITPOS;

  logic [q2e_pkg::ISQ_W-1:0] trial;

  assign trial = d.root + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (d.rem >= trial) begin
        q.rem  <= d.rem - trial;
        q.root <= (d.root >> 1) + BIT;
      end else begin
        q.rem  <= d.rem;
        q.root <= d.root >> 1;
      end
    end
  end

endmodule

>>> src/q2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation with a fixed shift, registered.
// Depends on q2e_pkg.
module q2e_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           en,
  input  q2e_pkg::rot_t  d,
  output q2e_pkg::rot_t  q
);

  logic signed [q2e_pkg::SUM_W-1:0] dx;
  logic signed [q2e_pkg::SUM_W-1:0] dy;

  assign dx = d.x >>> IDX;
  assign dy = d.y >>> IDX;

  always_ff @(posedge clk) begin
    if (en) begin
      q.zero <= d.zero;
      if (d.zero) begin
        q.x   <= d.x;
        q.y   <= d.y;
        q.ang <= d.ang;
      end else if (!d.y[q2e_pkg::SUM_W-1]) begin
        q.x   <= d.x + dy;
        q.y   <= d.y - dx;
        q.ang <= d.ang + q2e_pkg::ATAN_TURNS[IDX];
      end else begin
        q.x   <= d.x - dy;
        q.y   <= d.y + dx;
        q.ang <= d.ang - q2e_pkg::ATAN_TURNS[IDX];
      end
    end
  end

endmodule

>>> src/q2e_atan2.sv
// Pipelined atan2: half-plane fold, magnitude normalization, then a chain of CORDIC cells.
// Depends on q2e_pkg and q2e_cordic_cell.
module q2e_atan2 #(
  parameter int STEPS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [q2e_pkg::SUM_W-1:0]  y,
  input  logic signed [q2e_pkg::SUM_W-1:0]  x,
  output logic [q2e_pkg::ANG_W-1:0]         ang
);

  localparam int W = q2e_pkg::SUM_W;

  q2e_pkg::rot_t n1;
  q2e_pkg::rot_t n2;
  q2e_pkg::rot_t n3;
  q2e_pkg::rot_t n4;
  logic [W-1:0] n2_m;
  logic [W-1:0] m_c;
  logic [W-1:0] ax;
  logic [W-1:0] ay;
  logic                          nz_c   [q2e_pkg::GRP_N];
  logic [q2e_pkg::LEAD_W-1:0]    lead_c [q2e_pkg::GRP_N];
  logic                          n3_nz  [q2e_pkg::GRP_N];
  logic [q2e_pkg::LEAD_W-1:0]    n3_lead[q2e_pkg::GRP_N];
  logic [q2e_pkg::P_W-1:0]       p_c;
  logic [q2e_pkg::P_W-1:0]       n4_p;
  logic [q2e_pkg::P_W-1:0]       rsh;
  logic [q2e_pkg::P_W-1:0]       lsh;
  q2e_pkg::rot_t                 rot [STEPS+1];

  // fold the left half-plane onto the right
  always_ff @(posedge clk) begin
    if (en) begin
      n1.zero <= (y == '0);
      if (x[W-1]) begin
        n1.x   <= -x;
        n1.y   <= -y;
        n1.ang <= q2e_pkg::HALF_TURN;
      end else begin
        n1.x   <= x;
        n1.y   <= y;
        n1.ang <= '0;
      end
    end
  end

  always_comb begin
    ax  = n1.x[W-1] ? W'(-n1.x) : W'(n1.x);
    ay  = n1.y[W-1] ? W'(-n1.y) : W'(n1.y);
    m_c = (ax > ay) ? ax : ay;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2   <= n1;
      n2_m <= m_c;
    end
  end

  always_comb begin
    for (int g = 0; g < q2e_pkg::GRP_N; g++) begin
      nz_c[g]   = |n2_m[g*q2e_pkg::GRP_W +: q2e_pkg::GRP_W];
      lead_c[g] = '0;
      for (int b = 0; b < q2e_pkg::GRP_W; b++) begin
        if (n2_m[g*q2e_pkg::GRP_W + b]) begin
          lead_c[g] = q2e_pkg::LEAD_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3 <= n2;
      for (int g = 0; g < q2e_pkg::GRP_N; g++) begin
        n3_nz[g]   <= nz_c[g];
        n3_lead[g] <= lead_c[g];
      end
    end
  end

  always_comb begin
    p_c = '0;
    for (int g = 0; g < q2e_pkg::GRP_N; g++) begin
      if (n3_nz[g]) begin
        p_c = q2e_pkg::P_W'(g * q2e_pkg::GRP_W) + q2e_pkg::P_W'(n3_lead[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n4   <= n3;
      n4_p <= p_c;
    end
  end

  // bring the larger magnitude into [2^29, 2^30)
  assign rsh = n4_p - q2e_pkg::P_W'(q2e_pkg::NORM_MSB);
  assign lsh = q2e_pkg::P_W'(q2e_pkg::NORM_MSB) - n4_p;

  always_ff @(posedge clk) begin
    if (en) begin
      rot[0].ang  <= n4.ang;
      rot[0].zero <= n4.zero;
      if (n4_p > q2e_pkg::P_W'(q2e_pkg::NORM_MSB)) begin
        rot[0].x <= n4.x >>> rsh;
        rot[0].y <= n4.y >>> rsh;
      end else begin
        rot[0].x <= n4.x <<< lsh;
        rot[0].y <= n4.y <<< lsh;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    q2e_cordic_cell #(
      .IDX (i)
    ) u_cell (
      .clk (clk),
      .en  (en),
      .d   (rot[i]),
      .q   (rot[i+1])
    );
  end

  assign ang = rot[STEPS].ang;

endmodule

>>> src/quaternion_to_euler_angles.sv
// Top level of the quaternion to Z-Y-X Euler angle converter.
// Depends on q2e_pkg, q2e_sqrt_cell and q2e_atan2.
//
// Usage:
//   Input channel s_axis carries one unit quaternion per request, four signed
//   Q2.14 words. Output channel m_axis carries roll, pitch and yaw as signed
//   16-bit binary angles (65536 per turn) in the same order as the requests.
//   Throughput is one request per cycle while s_axis_tready is high. The
//   pipeline depth from input handshake to m_axis_tvalid is set by the
//   31-cell square root chain, five normalization stages and the CORDIC cell
//   chain of the pitch path; roll and yaw are delayed to match.
//   The whole pipeline advances while the skid register is empty, so a stalled
//   receiver holds one result in the output register, the next in the skid
//   register, and then deasserts s_axis_tready until the skid drains.
//   Reset clears all valid flags; in-flight requests are dropped and
//   s_axis_tready is high in the first cycle after reset.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [q2e_pkg::IN_W-1:0]   s_axis_tdata,   // qw, qx, qy, qz
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [q2e_pkg::OUT_W-1:0]  m_axis_tdata    // roll, pitch, yaw
);

  localparam int W     = q2e_pkg::SUM_W;
  localparam int LA    = q2e_pkg::NORM_STAGES + CORDIC_STEPS;
  localparam int PRE   = 3 + q2e_pkg::ISQ_STEPS;
  localparam int DEPTH = 2 + PRE + LA;
  localparam int FL_N  = PRE + LA;

  logic adv;
  logic s_fire;
  logic [DEPTH-1:0] vld;

  logic signed [q2e_pkg::Q_W-1:0] qw, qx, qy, qz;
  logic signed [q2e_pkg::PROD_W-1:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  logic signed [W-1:0] sr, cr, sp, sy, cy;

  logic signed [q2e_pkg::S30_W-1:0] s30_c;
  logic signed [q2e_pkg::S30_W-1:0] s30d [PRE];
  q2e_pkg::pflag_t                  fl   [FL_N];
  logic [q2e_pkg::MAG_W-1:0]        s_mag;
  logic [q2e_pkg::SQ_W-1:0]         sq;
  q2e_pkg::isq_t                    isq  [q2e_pkg::ISQ_STEPS+1];

  logic [q2e_pkg::ANG_W-1:0] roll_ang, yaw_ang, pitch_ang;
  logic [q2e_pkg::ANG_W-1:0] ry_roll [PRE];
  logic [q2e_pkg::ANG_W-1:0] ry_yaw  [PRE];
  logic signed [W-1:0]       py, px;

  logic [q2e_pkg::ANG_W-1:0]        r_roll, r_pitch, r_yaw;
  logic signed [q2e_pkg::Q_W-1:0]   roll_c, pitch_c, yaw_c, pa;
  logic [q2e_pkg::OUT_W-1:0]        res_c;
  logic [q2e_pkg::OUT_W-1:0]        o_data, skid_data;
  logic                             o_valid, skid_valid;

  assign adv           = !skid_valid;
  assign s_axis_tready = adv;
  assign s_fire        = s_axis_tvalid && adv;

  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], s_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr <= (W'(p_wx) + W'(p_yz)) <<< 1;
      cr <= q2e_pkg::ONE - ((W'(p_xx) + W'(p_yy)) <<< 1);
      sp <= (W'(p_wy) - W'(p_zx)) <<< 1;
      sy <= (W'(p_wz) + W'(p_xy)) <<< 1;
      cy <= q2e_pkg::ONE - ((W'(p_yy) + W'(p_zz)) <<< 1);
    end
  end

  // pitch sine in Q30, saturation flags
  assign s30_c = q2e_pkg::S30_W'(sp <<< q2e_pkg::S30_SHL);

  always_ff @(posedge clk) begin
    if (adv) begin
      s30d[0]     <= s30_c;
      fl[0].sat   <= (sp >= q2e_pkg::ONE) || (sp <= -q2e_pkg::ONE);
      fl[0].spos  <= !sp[W-1];
      for (int k = 1; k < PRE; k++) begin
        s30d[k] <= s30d[k-1];
      end
      for (int k = 1; k < FL_N; k++) begin
        fl[k] <= fl[k-1];
      end
    end
  end

  assign s_mag = s30d[0][q2e_pkg::S30_W-1] ? q2e_pkg::MAG_W'(-s30d[0])
                                            : q2e_pkg::MAG_W'(s30d[0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      sq          <= s_mag * s_mag;
      isq[0].rem  <= q2e_pkg::SQ_ONE - q2e_pkg::ISQ_W'(sq);
      isq[0].root <= '0;
    end
  end

  for (genvar j = 0; j < q2e_pkg::ISQ_STEPS; j++) begin : g_sqrt
    q2e_sqrt_cell #(
      .BITPOS (2 * (q2e_pkg::ISQ_STEPS - 1 - j))
    ) u_sqrt (
      .clk (clk),
      .en  (adv),
      .d   (isq[j]),
      .q   (isq[j+1])
    );
  end

  q2e_atan2 #(
    .STEPS (CORDIC_STEPS)
  ) u_roll (
    .clk (clk),
    .en  (adv),
    .y   (sr),
    .x   (cr),
    .ang (roll_ang)
  );

  q2e_atan2 #(
    .STEPS (CORDIC_STEPS)
  ) u_yaw (
    .clk (clk),
    .en  (adv),
    .y   (sy),
    .x   (cy),
    .ang (yaw_ang)
  );

  assign py = W'(s30d[PRE-1]);
  assign px = W'(isq[q2e_pkg::ISQ_STEPS].root[q2e_pkg::ROOT_W-1:0]);

  q2e_atan2 #(
    .STEPS (CORDIC_STEPS)
  ) u_pitch (
    .clk (clk),
    .en  (adv),
    .y   (py),
    .x   (px),
    .ang (pitch_ang)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ry_roll[0] <= roll_ang;
      ry_yaw[0]  <= yaw_ang;
      for (int k = 1; k < PRE; k++) begin
        ry_roll[k] <= ry_roll[k-1];
        ry_yaw[k]  <= ry_yaw[k-1];
      end
    end
  end

  // round to 16-bit binary angles, clamp pitch
  always_comb begin
    r_roll  = ry_roll[PRE-1] + q2e_pkg::ROUND_HALF;
    r_yaw   = ry_yaw[PRE-1] + q2e_pkg::ROUND_HALF;
    r_pitch = pitch_ang + q2e_pkg::ROUND_HALF;
    roll_c  = r_roll[31:16];
    yaw_c   = r_yaw[31:16];
    pa      = r_pitch[31:16];
    if (fl[FL_N-1].sat) begin
      pitch_c = fl[FL_N-1].spos ? q2e_pkg::QUARTER_POS : q2e_pkg::QUARTER_NEG;
    end else if (pa > q2e_pkg::QUARTER_POS) begin
      pitch_c = q2e_pkg::QUARTER_POS;
    end else if (pa < q2e_pkg::QUARTER_NEG) begin
      pitch_c = q2e_pkg::QUARTER_NEG;
    end else begin
      pitch_c = pa;
    end
    res_c = {yaw_c, pitch_c, roll_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        o_valid    <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (vld[DEPTH-1]) begin
      if (!o_valid || m_axis_tready) begin
        o_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) begin
        o_data <= skid_data;
      end
    end else if (vld[DEPTH-1]) begin
      if (!o_valid || m_axis_tready) begin
        o_data <= res_c;
      end else begin
        skid_data <= res_c;
      end
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;

endmodule

>>> src/q2e_checker.sv
// Port-level checks for quaternion_to_euler_angles and the bind that attaches them.
// Depends on q2e_pkg.
module q2e_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [q2e_pkg::OUT_W-1:0]  m_axis_tdata    // roll, pitch, yaw
);

  logic signed [q2e_pkg::Q_W-1:0] pitch;

  assign pitch = m_axis_tdata[31:16];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pitch <= q2e_pkg::QUARTER_POS) && (pitch >= q2e_pkg::QUARTER_NEG))
    else $error("pitch beyond a quarter turn");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("not empty after reset");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);

>>> tb/quaternion_to_euler_angles_test.sv
// Testbench of the quaternion to Z-Y-X Euler angle converter: directed and random quaternions,
// angles predicted in fixed point and compared in order. Depends on q2e_pkg and the top level.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [q2e_pkg::IN_W-1:0]    s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [q2e_pkg::OUT_W-1:0]   m_axis_tdata;

  angles_t angle_queue[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;

  quaternion_to_euler_angles dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] atan2_turns(input longint sy, input longint sx);
    logic [31:0] ang;
    longint m, nx, ny, ax, ay;
    ang = 32'h0;
    if (sy == 0) return (sx < 0) ? q2e_pkg::HALF_TURN : 32'h0;
    if (sx < 0) begin
      sx = -sx;
      sy = -sy;
      ang = q2e_pkg::HALF_TURN;
    end
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    m = (ax > ay) ? ax : ay;
    while (m >= (64'sd1 <<< 30)) begin
      sx = sx >>> 1;
      sy = sy >>> 1;
      m = m >>> 1;
    end
    while (m < (64'sd1 <<< 29)) begin
      sx = sx * 2;
      sy = sy * 2;
      m = m * 2;
    end
    for (int i = 0; i < 16 && i < q2e_pkg::ATAN_LEN; i++) begin
      if (sy >= 0) begin
        nx = sx + (sy >>> i);
        ny = sy - (sx >>> i);
        ang = ang + q2e_pkg::ATAN_TURNS[i];
      end else begin
        nx = sx - (sy >>> i);
        ny = sy + (sx >>> i);
        ang = ang - q2e_pkg::ATAN_TURNS[i];
      end
      sx = nx;
      sy = ny;
    end
    return ang;
  endfunction

  function automatic logic signed [15:0] round_angle(input logic [31:0] ang);
    logic [31:0] r;
    r = ang + q2e_pkg::ROUND_HALF;
    return r[31:16];
  endfunction

  function automatic longint floor_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic angles_t predict_angles(input logic [q2e_pkg::IN_W-1:0] d);
    angles_t a;
    longint w, x, y, z, one, sr, cr, sp, sy, cy, s30, c;
    int k, p;
    w = longint'($signed(d[15:0]));
    x = longint'($signed(d[31:16]));
    y = longint'($signed(d[47:32]));
    z = longint'($signed(d[63:48]));
    one = 64'sd1 <<< (2 * q2e_pkg::QUAT_FRAC_BITS);
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    a.roll = round_angle(atan2_turns(sr, cr));
    a.yaw = round_angle(atan2_turns(sy, cy));
    if (((sp < 0) ? -sp : sp) >= one) begin
      a.pitch = (sp > 0) ? q2e_pkg::QUARTER_POS : q2e_pkg::QUARTER_NEG;
    end else begin
      k = 2 * q2e_pkg::QUAT_FRAC_BITS - 30;
      s30 = (k >= 0) ? (sp >>> k) : (sp <<< (-k));
      c = floor_sqrt((64'd1 << 60) - 64'(s30 * s30));
      p = int'(round_angle(atan2_turns(s30, c)));
      if (p > 16384) p = 16384;
      if (p < -16384) p = -16384;
      a.pitch = 16'(p);
    end
    return a;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("quaternion_to_euler_angles: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    angles_t got, want;
    if (!rst && s_axis_tvalid && s_axis_tready) angle_queue.push_back(predict_angles(s_axis_tdata));
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (angle_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = angle_queue.pop_front();
        if (got.roll !== want.roll || got.pitch !== want.pitch || got.yaw !== want.yaw) begin
          mismatches++;
          if (mismatches <= 10)
            $display("roll/pitch/yaw expected %0d %0d %0d got %0d %0d %0d",
                     want.roll, want.pitch, want.yaw, got.roll, got.pitch, got.yaw);
        end
      end
    end
  end

  task automatic send_quat(input logic signed [15:0] w, x, y, z);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x, w};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_random_quat();
    real a, b, c, d, n;
    int kind;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (kind < 20) begin
      a = $urandom_range(11000, 11800);
      b = $urandom_range(0, 400);
      send_quat(16'($rtoi(a)), 16'($rtoi(b)) - 16'sd200, ($urandom_range(1) ? 16'($rtoi(a))
                : -16'($rtoi(a))), 16'($urandom_range(0, 400)) - 16'sd200);
    end else begin
      n = 0.0;
      while (n < 1.0) begin
        a = real'($urandom_range(65535)) - 32768.0;
        b = real'($urandom_range(65535)) - 32768.0;
        c = real'($urandom_range(65535)) - 32768.0;
        d = real'($urandom_range(65535)) - 32768.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
      end
      send_quat(16'($rtoi(a * 16384.0 / n)), 16'($rtoi(b * 16384.0 / n)),
                16'($rtoi(c * 16384.0 / n)), 16'($rtoi(d * 16384.0 / n)));
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (angle_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, -16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(16'sd0, 16'sd0, -16'sd16384, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
    send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
    send_quat(16'sd11586, 16'sd0, 16'sd11586, 16'sd0);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
    send_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
    send_quat(16'sd11585, 16'sd0, 16'sd0, -16'sd11585);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'sd16383, 16'sd1, -16'sd1, 16'sd0);
    send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send_quat(-16'sd1, 16'sd16383, 16'sd0, 16'sd0);
    wait_drained();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_random_quat();
  endtask

  task automatic test_pause_until_drained();
    idle_pct = 0;
    stall_pct = 30;
    for (int i = 0; i < 20; i++) send_random_quat();
    wait_drained();
    for (int i = 0; i < 30; i++) send_random_quat();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(450, 0, 0);
    test_random(350, 80, 0);
    test_random(350, 0, 80);
    test_random(450, 6, 6);
    test_pause_until_drained();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && angle_queue.size() == 0) begin
      $display("quaternion_to_euler_angles: match");
    end else begin
      $display("quaternion_to_euler_angles: mismatch");
    end
    $finish;
  end

endmodule
